// ----- hdl/arsr_pkg.sv -----
// ---------------------------------------------------------------------------
// Adaptive rate resampler package
// Shared widths, codes, reset values and word types for the resampler.
// ---------------------------------------------------------------------------
`default_nettype none

package arsr_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int PTR_BITS       = 32;
	localparam int FRAC_BITS      = 32;
	localparam int STEP_BITS      = 34;
	localparam int GAIN_BITS      = 20;
	localparam int CFG_INDEX_BITS = 1;
	localparam int BUFFER_DEPTH   = 2048;
	localparam int OUTQ_DEPTH     = 4;
	localparam int OUTQ_BITS      = $clog2(OUTQ_DEPTH);

	localparam logic [STEP_BITS-1:0] NOMINAL_RESET = 34'd4294967296;
	localparam logic [GAIN_BITS-1:0] GAIN_RESET    = 20'd39786;
	localparam logic [STEP_BITS-1:0] STEP_MAX      = {STEP_BITS{1'b1}};

	localparam logic [CFG_INDEX_BITS-1:0] CFG_NOMINAL = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN    = 1'd1;

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_PULL = 1'b1;

	typedef enum logic [1:0] {
		FILL_NORMAL   = 2'd0,
		FILL_UNDERRUN = 2'd1,
		FILL_OVERRUN  = 2'd2
	} fill_status_t;

	typedef struct packed {
		logic                          mode;
		logic signed [SAMPLE_BITS-1:0] left_in;
		logic signed [SAMPLE_BITS-1:0] right_in;
		logic                          block_start;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_out;
		logic signed [SAMPLE_BITS-1:0] right_out;
		fill_status_t                  fill_status;
	} out_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left;
		logic signed [SAMPLE_BITS-1:0] right;
	} pair_t;

	// Side information that travels with a pull alongside the store read.
	typedef struct packed {
		logic [FRAC_BITS-1:0] frac;
		fill_status_t         status;
	} pull_info_t;

endpackage

`default_nettype wire

// ----- hdl/adaptive_rate_stereo_resampler.sv -----
// ---------------------------------------------------------------------------
// Adaptive rate stereo resampler
// Ring store of stereo pairs read at a fractional, fill-steered position.
// ---------------------------------------------------------------------------
// Input words arrive on item/item_valid and are taken when item_stall is low.
// A push word writes one left/right pair into the ring store and yields no
// result. A pull word yields exactly one result word on result/result_valid:
// the pair interpolated between the two entries at the read position, or
// zeros with an underrun or overrun status. The receiver holds result_stall
// high to stop delivery; results then wait in a four-word queue, and input
// words keep being taken until queued and in-flight results fill the queue.
// A pull's result passes the store read registers, the interpolator's second
// stage registers and the output queue before result_valid rises. The block
// takes one word per cycle while item_stall is low; a normal pull that opens
// a block (block_start) retunes the phase step in the following cycle,
// during which item_stall is high. The store has one write port and two
// registered read ports, so both entries of a pull are fetched in the cycle
// it is accepted. After reset the store is cleared one entry per cycle, and
// item_stall stays high meanwhile. Configuration writes
// on cfg_valid/cfg_index/cfg_data are always ready and should only be issued
// while no pull is outstanding.
// ---------------------------------------------------------------------------
`default_nettype none

module adaptive_rate_stereo_resampler #(
	parameter int BUFFER_DEPTH = arsr_pkg::BUFFER_DEPTH
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                item_valid,
	output logic                                     item_stall,
	input  wire arsr_pkg::in_item_t                  item,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output arsr_pkg::out_item_t                      result,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [arsr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [arsr_pkg::STEP_BITS-1:0]      cfg_data
);

	localparam int ADDR_BITS = $clog2(BUFFER_DEPTH);
	localparam int QB        = arsr_pkg::OUTQ_BITS;

	logic                   accept;
	logic                   clearing;
	logic                   upd_pending;
	logic                   room;

	logic                   wr_en;
	logic [ADDR_BITS-1:0]   wr_addr;
	arsr_pkg::pair_t        wr_data;
	logic                   rd_en;
	logic [ADDR_BITS-1:0]   rd_addr0;
	logic [ADDR_BITS-1:0]   rd_addr1;
	arsr_pkg::pair_t        rd_data0;
	arsr_pkg::pair_t        rd_data1;

	logic                   valid_s1;
	arsr_pkg::pull_info_t   info_s1;
	logic                   valid_s2;
	arsr_pkg::out_item_t    res_s2;
	logic [QB:0]            q_count;
	logic [QB+1:0]          occupancy;

	// Every pull in the interpolator has a place reserved in the queue, so the
	// pipeline itself never has to stop.
	assign occupancy  = {1'b0, q_count} + (QB + 2)'(valid_s1) + (QB + 2)'(valid_s2);
	assign room       = occupancy < (QB + 2)'(arsr_pkg::OUTQ_DEPTH);
	assign item_stall = clearing || upd_pending || !room;
	assign accept     = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	arsr_ctrl #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.item        (item),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_en       (rd_en),
		.rd_addr0    (rd_addr0),
		.rd_addr1    (rd_addr1),
		.valid_s1    (valid_s1),
		.info_s1     (info_s1),
		.upd_pending (upd_pending)
	);

	arsr_store #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr0 (rd_addr0),
		.rd_addr1 (rd_addr1),
		.rd_data0 (rd_data0),
		.rd_data1 (rd_data1),
		.clearing (clearing)
	);

	arsr_interp u_interp (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.info_s1  (info_s1),
		.rd_data0 (rd_data0),
		.rd_data1 (rd_data1),
		.valid_s2 (valid_s2),
		.res      (res_s2)
	);

	arsr_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (valid_s2),
		.push_data    (res_s2),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.count        (q_count)
	);

endmodule

`default_nettype wire

// ----- hdl/arsr_store.sv -----
// ---------------------------------------------------------------------------
// Resampler sample store
// Ring of stereo pairs: one write port, two registered read ports, and a
// clearing sweep after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module arsr_store #(
	parameter int BUFFER_DEPTH = arsr_pkg::BUFFER_DEPTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr,
	input  wire arsr_pkg::pair_t                 wr_data,
	input  wire logic                            rd_en,
	input  wire logic [$clog2(BUFFER_DEPTH)-1:0] rd_addr0,
	input  wire logic [$clog2(BUFFER_DEPTH)-1:0] rd_addr1,
	output arsr_pkg::pair_t                      rd_data0,
	output arsr_pkg::pair_t                      rd_data1,
	output logic                                 clearing
);

	localparam int ADDR_BITS = $clog2(BUFFER_DEPTH);

	arsr_pkg::pair_t        mem [BUFFER_DEPTH];
	logic                   clear_q;
	logic [ADDR_BITS-1:0]   clr_idx_q;
	arsr_pkg::pair_t        rd_data0_q;
	arsr_pkg::pair_t        rd_data1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q   <= 1'b1;
			clr_idx_q <= '0;
		end else if (clear_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == ADDR_BITS'(BUFFER_DEPTH - 1)) begin
				clear_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clear_q) begin
			mem[clr_idx_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data0_q <= mem[rd_addr0];
			rd_data1_q <= mem[rd_addr1];
		end
	end

	assign rd_data0 = rd_data0_q;
	assign rd_data1 = rd_data1_q;
	assign clearing = clear_q;

endmodule

`default_nettype wire

// ----- hdl/arsr_ctrl.sv -----
// ---------------------------------------------------------------------------
// Resampler pointer and phase control
// Holds the pointers, phase and step, classifies pulls and retunes the step.
// ---------------------------------------------------------------------------
`default_nettype none

module arsr_ctrl #(
	parameter int BUFFER_DEPTH = arsr_pkg::BUFFER_DEPTH
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    accept,
	input  wire arsr_pkg::in_item_t                      item,
	input  wire logic                                    cfg_we,
	input  wire logic [arsr_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  wire logic [arsr_pkg::STEP_BITS-1:0]          cfg_data,
	output logic                                         wr_en,
	output logic [$clog2(BUFFER_DEPTH)-1:0]              wr_addr,
	output arsr_pkg::pair_t                              wr_data,
	output logic                                         rd_en,
	output logic [$clog2(BUFFER_DEPTH)-1:0]              rd_addr0,
	output logic [$clog2(BUFFER_DEPTH)-1:0]              rd_addr1,
	output logic                                         valid_s1,
	output arsr_pkg::pull_info_t                         info_s1,
	output logic                                         upd_pending
);

	localparam int ADDR_BITS = $clog2(BUFFER_DEPTH);
	localparam int HALF      = BUFFER_DEPTH / 2;
	localparam int SUM_BITS  = arsr_pkg::STEP_BITS + 1;
	localparam int PROD_BITS = ADDR_BITS + arsr_pkg::GAIN_BITS + 1;
	localparam int NEW_BITS  = ((PROD_BITS > SUM_BITS) ? PROD_BITS : SUM_BITS) + 1;
	localparam int PB        = arsr_pkg::PTR_BITS;
	localparam int FB        = arsr_pkg::FRAC_BITS;
	localparam int SB        = arsr_pkg::STEP_BITS;

	logic [PB-1:0]                      wp_q;
	logic [PB-1:0]                      rp_q;
	logic [FB-1:0]                      frac_q;
	logic [SB-1:0]                      step_q;
	logic [SB-1:0]                      nominal_q;
	logic [arsr_pkg::GAIN_BITS-1:0]     gain_q;
	logic                               upd_q;
	logic signed [ADDR_BITS-1:0]        qfill_q;
	logic                               valid_s1_q;
	arsr_pkg::pull_info_t               info_s1_q;

	logic [PB-1:0]                      fill;
	logic                               under;
	logic                               over;
	logic                               is_pull;
	logic [SUM_BITS-1:0]                phase_sum;
	arsr_pkg::fill_status_t             status;
	logic signed [arsr_pkg::GAIN_BITS:0] gain_s;
	logic signed [PROD_BITS-1:0]        prod;
	logic signed [NEW_BITS-1:0]         new_step;
	logic [SB-1:0]                      step_clamped;

	assign fill      = wp_q - rp_q;
	assign under     = (fill == '0) || fill[PB-1];
	assign over      = !under && (fill >= PB'(BUFFER_DEPTH - 1));
	assign is_pull   = (item.mode == arsr_pkg::MODE_PULL);
	assign phase_sum = {{(SUM_BITS - FB){1'b0}}, frac_q} + {1'b0, step_q};

	always_comb begin
		if (under) begin
			status = arsr_pkg::FILL_UNDERRUN;
		end else if (over) begin
			status = arsr_pkg::FILL_OVERRUN;
		end else begin
			status = arsr_pkg::FILL_NORMAL;
		end
	end

	// Retune: nominal plus fill error times gain, clamped to the step range.
	assign gain_s   = $signed({1'b0, gain_q});
	assign prod     = qfill_q * gain_s;
	assign new_step = $signed({{(NEW_BITS - SB){1'b0}}, nominal_q})
		+ $signed({{(NEW_BITS - PROD_BITS){prod[PROD_BITS-1]}}, prod});

	always_comb begin
		if (new_step[NEW_BITS-1]) begin
			step_clamped = '0;
		end else if (|new_step[NEW_BITS-2:SB]) begin
			step_clamped = arsr_pkg::STEP_MAX;
		end else begin
			step_clamped = new_step[SB-1:0];
		end
	end

	assign wr_en         = accept && !is_pull;
	assign wr_addr       = wp_q[ADDR_BITS-1:0];
	assign wr_data.left  = item.left_in;
	assign wr_data.right = item.right_in;
	assign rd_en         = accept && is_pull;
	assign rd_addr0      = rp_q[ADDR_BITS-1:0];
	assign rd_addr1      = rp_q[ADDR_BITS-1:0] + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			rp_q       <= '0;
			frac_q     <= '0;
			step_q     <= arsr_pkg::NOMINAL_RESET;
			nominal_q  <= arsr_pkg::NOMINAL_RESET;
			gain_q     <= arsr_pkg::GAIN_RESET;
			upd_q      <= 1'b0;
			valid_s1_q <= 1'b0;
		end else begin
			valid_s1_q <= accept && is_pull;
			if (upd_q) begin
				step_q <= step_clamped;
				upd_q  <= 1'b0;
			end
			if (accept && !is_pull) begin
				wp_q <= wp_q + 1'b1;
			end
			if (accept && is_pull) begin
				if (over) begin
					rp_q <= wp_q - PB'(HALF);
				end else if (!under) begin
					rp_q   <= rp_q + {{(PB - (SUM_BITS - FB)){1'b0}}, phase_sum[SUM_BITS-1:FB]};
					frac_q <= phase_sum[FB-1:0];
					if (item.block_start) begin
						upd_q <= 1'b1;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					arsr_pkg::CFG_NOMINAL: begin
						nominal_q <= cfg_data;
						step_q    <= cfg_data;
					end
					arsr_pkg::CFG_GAIN: begin
						gain_q <= cfg_data[arsr_pkg::GAIN_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// The fill error is fill minus half the depth; for a normal pull it fits
	// the address width as a signed value.
	always_ff @(posedge clk) begin
		if (accept && is_pull) begin
			info_s1_q.frac   <= frac_q;
			info_s1_q.status <= status;
			qfill_q          <= $signed(fill[ADDR_BITS-1:0] - ADDR_BITS'(HALF));
		end
	end

	assign valid_s1    = valid_s1_q;
	assign info_s1     = info_s1_q;
	assign upd_pending = upd_q;

endmodule

`default_nettype wire

// ----- hdl/arsr_interp.sv -----
// ---------------------------------------------------------------------------
// Resampler interpolator
// Two-stage linear interpolation of both channels with round to nearest.
// ---------------------------------------------------------------------------
`default_nettype none

module arsr_interp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 valid_s1,
	input  wire arsr_pkg::pull_info_t info_s1,
	input  wire arsr_pkg::pair_t      rd_data0,
	input  wire arsr_pkg::pair_t      rd_data1,
	output logic                      valid_s2,
	output arsr_pkg::out_item_t       res
);

	localparam int S  = arsr_pkg::SAMPLE_BITS;
	localparam int FB = arsr_pkg::FRAC_BITS;
	localparam int PW = S + FB;

	logic signed [S-1:0]    a       [2];
	logic signed [S-1:0]    b       [2];
	logic signed [S:0]      diff    [2];
	logic [S-1:0]           mag     [2];
	logic [PW-1:0]          prod    [2];
	logic [PW:0]            total   [2];
	logic [S-1:0]           step    [2];
	logic [S:0]             r       [2];

	logic                   valid_s2_q;
	arsr_pkg::fill_status_t status_s2;
	logic signed [S-1:0]    a_s2    [2];
	logic                   neg_s2  [2];
	logic [PW-1:0]          prod_s2 [2];

	assign a[0] = rd_data0.left;
	assign a[1] = rd_data0.right;
	assign b[0] = rd_data1.left;
	assign b[1] = rd_data1.right;

	always_comb begin
		for (int ch = 0; ch < 2; ch++) begin
			diff[ch]  = {b[ch][S-1], b[ch]} - {a[ch][S-1], a[ch]};
			mag[ch]   = diff[ch][S] ? S'(-diff[ch]) : diff[ch][S-1:0];
			prod[ch]  = PW'(mag[ch]) * PW'(info_s1.frac);
			// A falling segment rounds half a step toward plus infinity too.
			total[ch] = {1'b0, prod_s2[ch]}
				+ (neg_s2[ch] ? (PW + 1)'(32'h7FFF_FFFF) : (PW + 1)'(32'h8000_0000));
			step[ch]  = total[ch][PW-1:FB];
			r[ch]     = neg_s2[ch] ? ({a_s2[ch][S-1], a_s2[ch]} - {1'b0, step[ch]})
				: ({a_s2[ch][S-1], a_s2[ch]} + {1'b0, step[ch]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2_q <= 1'b0;
		end else begin
			valid_s2_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_s2 <= info_s1.status;
			for (int ch = 0; ch < 2; ch++) begin
				a_s2[ch]    <= a[ch];
				neg_s2[ch]  <= diff[ch][S];
				prod_s2[ch] <= prod[ch];
			end
		end
	end

	always_comb begin
		res.fill_status = status_s2;
		if (status_s2 == arsr_pkg::FILL_NORMAL) begin
			res.left_out  = r[0][S-1:0];
			res.right_out = r[1][S-1:0];
		end else begin
			res.left_out  = '0;
			res.right_out = '0;
		end
	end

	assign valid_s2 = valid_s2_q;

endmodule

`default_nettype wire

// ----- hdl/arsr_outq.sv -----
// ---------------------------------------------------------------------------
// Resampler output queue
// Small result queue that decouples the pipeline from receiver stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module arsr_outq (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire arsr_pkg::out_item_t           push_data,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output arsr_pkg::out_item_t                result,
	output logic [arsr_pkg::OUTQ_BITS:0]       count
);

	localparam int QB = arsr_pkg::OUTQ_BITS;

	arsr_pkg::out_item_t q_mem [arsr_pkg::OUTQ_DEPTH];
	logic [QB-1:0]       wr_ptr_q;
	logic [QB-1:0]       rd_ptr_q;
	logic [QB:0]         count_q;
	logic                pop;

	assign pop = (count_q != '0) && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= push_data;
		end
	end

	assign result_valid = (count_q != '0);
	assign result       = q_mem[rd_ptr_q];
	assign count        = count_q;

endmodule

`default_nettype wire

// ----- tb/adaptive_rate_stereo_resampler_test.sv -----
// ---------------------------------------------------------------------------
// Adaptive rate stereo resampler testbench
// Pushes and pulls stereo words through the resampler under random flow
// control and checks every result word against a behavioural copy of the
// ring store, the fractional read position and the fill-steered phase step.
// ---------------------------------------------------------------------------
`default_nettype none

module adaptive_rate_stereo_resampler_test;

	timeunit 1ns;
	timeprecision 1ps;

	// Cycles of silence on every channel before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 8000;
	// Quiet cycles allowed after the last result, so that a push still in
	// flight has landed before a register write or the end of the run.
	localparam int SETTLE_CYCLES  = 8;
	localparam int MAX_GAP        = 18;

	localparam int SB = arsr_pkg::SAMPLE_BITS;
	localparam int PB = arsr_pkg::PTR_BITS;
	localparam int FB = arsr_pkg::FRAC_BITS;
	localparam int TB = arsr_pkg::STEP_BITS;
	localparam int GB = arsr_pkg::GAIN_BITS;
	localparam int DEPTH = arsr_pkg::BUFFER_DEPTH;

	localparam logic signed [SB-1:0] SMP_MAX   = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] SMP_MIN   = {1'b1, {(SB-1){1'b0}}};
	localparam logic [PB-1:0]        RING_MASK = PB'(DEPTH - 1);

	// One row of the opening sequence. Where typed is set, want holds the
	// result word written out by hand; otherwise the model supplies it.
	typedef struct {
		arsr_pkg::in_item_t  word;
		bit                  typed;
		arsr_pkg::out_item_t want;
	} stim_row_t;

	logic                                clk;
	logic                                arst_n;
	logic                                item_valid;
	logic                                item_stall;
	arsr_pkg::in_item_t                  item;
	logic                                result_valid;
	logic                                result_stall;
	arsr_pkg::out_item_t                 result;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [arsr_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [TB-1:0]                       cfg_data;

	// Behavioural copy of the resampler state.
	logic signed [SB-1:0] ring_left  [DEPTH];
	logic signed [SB-1:0] ring_right [DEPTH];
	logic [PB-1:0]        wr_pos;
	logic [PB-1:0]        rd_pos;
	logic [FB-1:0]        frac_acc;
	logic [TB-1:0]        step_now;
	logic [TB-1:0]        step_nominal;
	logic [GB-1:0]        fill_gain;

	// Result words owed by the block, oldest first.
	arsr_pkg::out_item_t due_pairs[$];

	int unsigned mismatches = 0;
	bit          tx_quiet   = 1'b0;
	bit          rx_quiet   = 1'b0;

	adaptive_rate_stereo_resampler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Linear interpolation from a towards b by frac/2^32, rounded to nearest
	// with ties going towards plus infinity. Working on the magnitude of the
	// span keeps the product unsigned; the bias differs with the direction so
	// that a tie still rounds upwards.
	function automatic logic signed [SB-1:0] interpolate(
		input logic signed [SB-1:0] a,
		input logic signed [SB-1:0] b,
		input logic [FB-1:0]        frac
	);
		longint          sa;
		longint          sb;
		longint          r;
		longint unsigned span;
		longint unsigned prod;
		sa = a;
		sb = b;
		if (sb >= sa) begin
			span = sb - sa;
			prod = span * frac;
			r = sa + longint'((prod + 64'h8000_0000) >> 32);
		end else begin
			span = sa - sb;
			prod = span * frac;
			r = sa - longint'((prod + 64'h7FFF_FFFF) >> 32);
		end
		return r[SB-1:0];
	endfunction

	// Applies one accepted input word to the model state and says whether it
	// yields a result word, and which.
	function automatic void resample_word(input arsr_pkg::in_item_t w, output bit produced,
			output arsr_pkg::out_item_t r);
		logic [PB-1:0] fill;
		logic [PB-1:0] i0;
		logic [PB-1:0] i1;
		logic [34:0]   phase_sum;
		longint        err;
		longint        retuned;
		produced = 1'b0;
		r = '0;
		if (w.mode == arsr_pkg::MODE_PUSH) begin
			ring_left[wr_pos & RING_MASK]  = w.left_in;
			ring_right[wr_pos & RING_MASK] = w.right_in;
			wr_pos++;
			return;
		end
		produced = 1'b1;
		fill = wr_pos - rd_pos;
		if (fill == 0 || fill[PB-1]) begin
			// Nothing to read: zeros, and the state stays as it is.
			r.fill_status = arsr_pkg::FILL_UNDERRUN;
			return;
		end
		if (fill >= PB'(DEPTH - 1)) begin
			// Too full: the read position jumps back to half a ring behind the
			// write position. Phase and step are kept.
			rd_pos = wr_pos - PB'(DEPTH / 2);
			r.fill_status = arsr_pkg::FILL_OVERRUN;
			return;
		end
		i0 = rd_pos & RING_MASK;
		i1 = (rd_pos + 1) & RING_MASK;
		r.left_out    = interpolate(ring_left[i0], ring_left[i1], frac_acc);
		r.right_out   = interpolate(ring_right[i0], ring_right[i1], frac_acc);
		r.fill_status = arsr_pkg::FILL_NORMAL;
		phase_sum = {3'b000, frac_acc} + {1'b0, step_now};
		rd_pos   += PB'(phase_sum[34:32]);
		frac_acc  = phase_sum[FB-1:0];
		if (w.block_start) begin
			// Retune from the fill level seen before this pull, clamped to the
			// range of the step register.
			err = longint'(fill) - DEPTH / 2;
			retuned = longint'(step_nominal) + err * longint'(fill_gain);
			if (retuned < 0)
				retuned = 0;
			if (retuned > longint'(arsr_pkg::STEP_MAX))
				retuned = longint'(arsr_pkg::STEP_MAX);
			step_now = retuned[TB-1:0];
		end
	endfunction

	function automatic int fill_now();
		return $signed(wr_pos - rd_pos);
	endfunction

	// Mostly full-range values, with the two extremes and values near zero
	// drawn often enough to exercise the rounding at both ends.
	function automatic logic signed [SB-1:0] random_sample();
		case ($urandom_range(0, 7))
			0: begin
				return SMP_MAX;
			end
			1: begin
				return SMP_MIN;
			end
			2: begin
				return SB'(int'($urandom_range(0, 8)) - 4);
			end
			default: begin
				return SB'($urandom);
			end
		endcase
	endfunction

	// A pull carries random samples too; the block must ignore them. Only an
	// occasional pull opens a block, while a push sets block_start freely.
	function automatic arsr_pkg::in_item_t random_word(input logic mode);
		arsr_pkg::in_item_t w;
		w.mode        = mode;
		w.left_in     = random_sample();
		w.right_in    = random_sample();
		w.block_start = (mode == arsr_pkg::MODE_PULL) ? ($urandom_range(0, 7) == 0)
				: 1'($urandom_range(0, 1));
		return w;
	endfunction

	function automatic stim_row_t push_row(input logic signed [SB-1:0] l,
			input logic signed [SB-1:0] r, input logic bs);
		stim_row_t row;
		row.word  = '{mode: arsr_pkg::MODE_PUSH, left_in: l, right_in: r, block_start: bs};
		row.typed = 1'b0;
		row.want  = '0;
		return row;
	endfunction

	function automatic stim_row_t pull_row(input logic bs);
		stim_row_t row;
		row.word  = '{mode: arsr_pkg::MODE_PULL, left_in: '0, right_in: '0, block_start: bs};
		row.typed = 1'b0;
		row.want  = '0;
		return row;
	endfunction

	function automatic stim_row_t pull_typed(input logic bs,
			input logic signed [SB-1:0] l, input logic signed [SB-1:0] r,
			input arsr_pkg::fill_status_t st);
		stim_row_t row;
		row = pull_row(bs);
		row.typed = 1'b1;
		row.want  = '{left_out: l, right_out: r, fill_status: st};
		return row;
	endfunction

	// Offers one input word after a random gap and holds it until it is
	// taken. Called and left on a falling edge; valid is only lowered when a
	// gap follows, so it never falls and rises in the same step.
	task automatic send_word(input arsr_pkg::in_item_t w, input bit typed,
			input arsr_pkg::out_item_t want);
		int unsigned         gap;
		bit                  produced;
		arsr_pkg::out_item_t modelled;
		gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
		if ($urandom_range(0, 31) == 0)
			tx_quiet = !tx_quiet;
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item       <= w;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (item_stall);
		resample_word(w, produced, modelled);
		if (produced)
			due_pairs.insert(due_pairs.size(), typed ? want : modelled);
		@(negedge clk);
	endtask

	// Holds the input side off until every owed result word has arrived and
	// any push still travelling through the block has settled.
	task automatic drain();
		item_valid <= 1'b0;
		while (due_pairs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input logic [arsr_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [TB-1:0] value);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == arsr_pkg::CFG_NOMINAL) begin
			// A new nominal step takes effect at once, not at the next block.
			step_nominal = value;
			step_now     = value;
		end else begin
			fill_gain = value[GB-1:0];
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_rates(input logic [TB-1:0] nominal,
			input logic [TB-1:0] gain_data, input bit gain_first);
		drain();
		if (gain_first) begin
			write_register(arsr_pkg::CFG_GAIN, gain_data);
			write_register(arsr_pkg::CFG_NOMINAL, nominal);
		end else begin
			write_register(arsr_pkg::CFG_NOMINAL, nominal);
			write_register(arsr_pkg::CFG_GAIN, gain_data);
		end
	endtask

	// Random traffic steered by the fill level, so that most pulls land in
	// the interpolating range while underruns still turn up now and then.
	// Once in a while the sender waits until every owed result word has arrived.
	task automatic random_words(input int count);
		int f;
		int pull_pct;
		repeat (count) begin
			f = fill_now();
			pull_pct = (f < 16) ? 25 : (f > 1800) ? 85 : 50;
			if ($urandom_range(0, 39) == 0)
				drain();
			send_word(random_word(($urandom_range(0, 99) < pull_pct) ? arsr_pkg::MODE_PULL
					: arsr_pkg::MODE_PUSH), 1'b0, '0);
		end
	endtask

	// Sets result_stall for a random number of cycles before each result
	// word, with quiet stretches in which every word is taken at once.
	initial begin : result_pacing
		int unsigned hold;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 31) == 0)
				rx_quiet = !rx_quiet;
			hold = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
			@(negedge clk);
			if (hold != 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			result_stall <= 1'b0;
			do
				@(posedge clk);
			while (!(result_valid && !result_stall));
		end
	end

	// Every result word taken is compared, field by field, with the oldest
	// word owed.
	always @(posedge clk) begin : result_check
		arsr_pkg::out_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (due_pairs.size() == 0) begin
				report($sformatf("result word %0d/%0d/%0d arrived with none owed",
						result.left_out, result.right_out, result.fill_status));
			end else begin
				want = due_pairs.pop_front();
				if (result.left_out !== want.left_out)
					report($sformatf("left_out %0d, expected %0d",
							result.left_out, want.left_out));
				if (result.right_out !== want.right_out)
					report($sformatf("right_out %0d, expected %0d",
							result.right_out, want.right_out));
				if (result.fill_status !== want.fill_status)
					report($sformatf("fill_status %0d, expected %0d",
							result.fill_status, want.fill_status));
			end
		end
	end

	// Ends the run if no channel moves a word for too long.
	initial begin : watchdog
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall)
					|| (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("adaptive_rate_stereo_resampler test failed");
		$finish;
	end

	initial begin : stimulus
		stim_row_t opening[$];
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		result_stall = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = arsr_pkg::CFG_NOMINAL;
		cfg_data     = '0;
		foreach (ring_left[i]) begin
			ring_left[i]  = '0;
			ring_right[i] = '0;
		end
		wr_pos       = '0;
		rd_pos       = '0;
		frac_acc     = '0;
		step_nominal = arsr_pkg::NOMINAL_RESET;
		step_now     = arsr_pkg::NOMINAL_RESET;
		fill_gain    = arsr_pkg::GAIN_RESET;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// Opening sequence at the reset rates. The empty ring underruns, with
		// and without a block start. Two extreme pairs then read back exactly
		// while the phase is still zero, and the ring runs dry again. After
		// that a retune at low fill drops the step below one, so the later
		// pulls interpolate between full-scale neighbours of either sign.
		opening = '{
			pull_typed(1'b0, '0, '0, arsr_pkg::FILL_UNDERRUN),
			pull_typed(1'b1, '0, '0, arsr_pkg::FILL_UNDERRUN),
			push_row(SMP_MAX, SMP_MIN, 1'b1),
			push_row(SMP_MIN, SMP_MAX, 1'b0),
			pull_typed(1'b0, SMP_MAX, SMP_MIN, arsr_pkg::FILL_NORMAL),
			pull_typed(1'b0, SMP_MIN, SMP_MAX, arsr_pkg::FILL_NORMAL),
			pull_typed(1'b0, '0, '0, arsr_pkg::FILL_UNDERRUN),
			push_row('0, '0, 1'b0),
			push_row(SMP_MAX, SMP_MAX, 1'b0),
			push_row(-24'sd1, 24'sd1, 1'b1),
			push_row(SMP_MIN, SMP_MIN, 1'b0),
			push_row(24'sd1, -24'sd2, 1'b0),
			pull_row(1'b1),
			pull_row(1'b0),
			pull_row(1'b0),
			pull_row(1'b1),
			push_row(-24'sd2, 24'sd1, 1'b0),
			push_row(SMP_MAX, SMP_MIN, 1'b0),
			pull_row(1'b0),
			pull_row(1'b0),
			pull_row(1'b0),
			pull_row(1'b0),
			pull_row(1'b1),
			pull_row(1'b0)
		};
		foreach (opening[i])
			send_word(opening[i].word, opening[i].typed, opening[i].want);
		random_words(140);

		// A stopped read position: the ring only fills.
		set_rates('0, '0, 1'b0);
		random_words(100);

		// The fastest step and the strongest gain; the upper gain bits of the
		// write word are junk that the register must drop.
		set_rates(arsr_pkg::STEP_MAX, {14'($urandom), {GB{1'b1}}}, 1'b1);
		random_words(140);

		// A tiny nominal step with full gain: a retune well below centre clamps
		// the step at zero until the fill climbs past the middle.
		set_rates(TB'($urandom_range(0, 1 << 24)), TB'({GB{1'b1}}), 1'b0);
		random_words(120);

		// Close to unity with a random gain, as in normal use.
		set_rates(arsr_pkg::NOMINAL_RESET + TB'($urandom_range(0, 1 << 28)) - TB'(1 << 27),
				TB'($urandom_range(0, (1 << GB) - 1)), 1'b1);
		random_words(150);

		item_valid <= 1'b0;
		while (due_pairs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("adaptive_rate_stereo_resampler test passed");
		else
			$display("adaptive_rate_stereo_resampler test failed");
		$finish;
	end

endmodule

`default_nettype wire
